// ----- src/lfu_pkg.sv -----
// lfu_pkg: shared types and constants for the LFU cache controller.
// Used by lfu_ctrl, lfu_datapath and the top level lfu_cache_controller.
`default_nettype none
package lfu_pkg;
	localparam int unsigned EntriesDefault = 16;
	localparam int unsigned CapW = 5;
	localparam int unsigned DataW = 32;
	localparam int unsigned StampW = 64;
	localparam logic [CapW-1:0] CapResetVal = 5'd16;
	localparam logic [DataW-1:0] CeilResetVal = 32'hFFFF_FFFF;
	localparam logic [DataW-1:0] MissValue = 32'hFFFF_FFFF;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_CEILING  = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request, start lookup/victim search
		logic commit;   // apply state update and build result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic dummy;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- src/lfu_ctrl.sv -----
// lfu_ctrl: request sequencer for the LFU cache (load, commit, hold result).
// Depends on lfu_pkg.
`default_nettype none
module lfu_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lfu_pkg::dp_cmd_t     cmd
);
	import lfu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;

	// a new request may enter while the last result still waits in its register
	// only once it has been taken; one item in flight at a time
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.commit = (state_q == ST_SEARCH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (cmd.load) state_d = ST_SEARCH;
			ST_SEARCH: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- src/lfu_datapath.sv -----
// lfu_datapath: entry storage, key match, registered victim search and update.
// Depends on lfu_pkg.
`default_nettype none
module lfu_datapath #(
	parameter int unsigned ENTRIES = lfu_pkg::EntriesDefault
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lfu_pkg::dp_cmd_t            cmd,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_idx,
	input  wire logic [lfu_pkg::DataW-1:0]   cfg_data,
	input  wire logic                        req_cmd,
	input  wire logic [lfu_pkg::DataW-1:0]   req_key,
	input  wire logic [lfu_pkg::DataW-1:0]   req_value,
	output logic                             res_hit,
	output logic [lfu_pkg::DataW-1:0]        res_read_value,
	output logic                             res_evicted,
	output logic [lfu_pkg::DataW-1:0]        res_evicted_key,
	output logic [lfu_pkg::CapW-1:0]         res_occupancy
);
	import lfu_pkg::*;

	localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CntW = $clog2(ENTRIES + 1);
	localparam int unsigned CmpW = ((CntW > CapW) ? CntW : CapW) + 1;
	localparam int unsigned Leaves = 1 << IdxW;
	localparam int unsigned Nodes = 2 * Leaves - 1;

	logic [CapW-1:0]   cap_q;
	logic [DataW-1:0]  ceil_q;
	logic [ENTRIES-1:0] valid_q;
	logic [DataW-1:0]  key_q   [ENTRIES];
	logic [DataW-1:0]  value_q [ENTRIES];
	logic [DataW-1:0]  count_q [ENTRIES];
	logic [StampW-1:0] stamp_q [ENTRIES];
	logic [StampW-1:0] clock_q;
	logic [CntW-1:0]   resident_q;

	logic              cmd_s1;
	logic [DataW-1:0]  key_s1, value_s1;
	logic              hit_s1, victim_ok_s1, free_ok_s1;
	logic [IdxW-1:0]   hit_idx_s1, victim_s1, free_s1;
	logic [CntW-1:0]   resident_s1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CapResetVal;
			ceil_q <= CeilResetVal;
		end else if (cfg_we) begin
			if (cfg_idx == REG_CAPACITY) cap_q <= cfg_data[CapW-1:0];
			else ceil_q <= cfg_data;
		end
	end

	// match and free search on stored state (stable while idle)
	logic              hit_c, victim_ok_c, free_ok_c;
	logic [IdxW-1:0]   hit_idx_c, victim_c, free_c;
	always_comb begin
		hit_c = 1'b0; hit_idx_c = '0;
		free_ok_c = 1'b0; free_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == req_key) begin
				hit_c = 1'b1; hit_idx_c = IdxW'(i);
			end
			if (!valid_q[i]) begin
				free_ok_c = 1'b1; free_c = IdxW'(i);
			end
		end
	end

	// victim tree: lowest count, then oldest stamp, lower index on equal
	logic              vt_ok    [Nodes];
	logic [IdxW-1:0]   vt_idx   [Nodes];
	logic [DataW-1:0]  vt_cnt   [Nodes];
	logic [StampW-1:0] vt_stamp [Nodes];
	logic              vt_right;
	always_comb begin
		vt_right = 1'b0;
		for (int i = 0; i < Leaves; i++) begin
			vt_ok[Leaves-1+i]    = (i < ENTRIES) && valid_q[IdxW'(i)];
			vt_idx[Leaves-1+i]   = IdxW'(i);
			vt_cnt[Leaves-1+i]   = (i < ENTRIES) ? count_q[IdxW'(i)] : '0;
			vt_stamp[Leaves-1+i] = (i < ENTRIES) ? stamp_q[IdxW'(i)] : '0;
		end
		for (int n = Leaves - 2; n >= 0; n--) begin
			vt_right = vt_ok[2*n+2] && (!vt_ok[2*n+1] ||
				vt_cnt[2*n+2] < vt_cnt[2*n+1] ||
				(vt_cnt[2*n+2] == vt_cnt[2*n+1] && vt_stamp[2*n+2] < vt_stamp[2*n+1]));
			vt_ok[n]    = vt_ok[2*n+1] || vt_ok[2*n+2];
			vt_idx[n]   = vt_right ? vt_idx[2*n+2] : vt_idx[2*n+1];
			vt_cnt[n]   = vt_right ? vt_cnt[2*n+2] : vt_cnt[2*n+1];
			vt_stamp[n] = vt_right ? vt_stamp[2*n+2] : vt_stamp[2*n+1];
		end
		victim_ok_c = vt_ok[0];
		victim_c    = vt_idx[0];
	end

	// stage 1: capture request and search results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1       <= req_cmd;
			key_s1       <= req_key;
			value_s1     <= req_value;
			hit_s1       <= hit_c;
			hit_idx_s1   <= hit_idx_c;
			victim_ok_s1 <= victim_ok_c;
			victim_s1    <= victim_c;
			free_ok_s1   <= free_ok_c;
			free_s1      <= free_c;
			resident_s1  <= resident_q;
		end
	end

	// capacity clipped to entry count
	logic [CmpW-1:0] cap_eff;
	assign cap_eff = (CmpW'(cap_q) > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : CmpW'(cap_q);
	logic [DataW-1:0] ceil_eff;
	assign ceil_eff = (ceil_q == '0) ? DataW'(1) : ceil_q;

	// after an eviction the new key takes the lowest free slot, victim included
	logic full, do_evict, do_insert;
	logic [IdxW-1:0] ins_idx;
	assign full      = CmpW'(resident_s1) >= cap_eff;
	assign do_evict  = (cmd_s1 == CMD_PUT) && (cap_eff != '0) && !hit_s1 && full && victim_ok_s1;
	assign ins_idx   = (do_evict && !(free_ok_s1 && free_s1 < victim_s1)) ? victim_s1 : free_s1;
	assign do_insert = (cmd_s1 == CMD_PUT) && (cap_eff != '0) && !hit_s1 &&
		(do_evict || free_ok_s1);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			clock_q    <= '0;
			resident_q <= '0;
		end else if (cmd.commit) begin
			if (hit_s1 && (cmd_s1 == CMD_GET || cap_eff != '0)) begin
				clock_q <= clock_q + StampW'(1);
			end else if (do_insert) begin
				if (do_evict && ins_idx != victim_s1) valid_q[victim_s1] <= 1'b0;
				valid_q[ins_idx] <= 1'b1;
				clock_q <= clock_q + StampW'(1);
				if (!do_evict) resident_q <= resident_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (hit_s1 && (cmd_s1 == CMD_GET || cap_eff != '0)) begin
				if (count_q[hit_idx_s1] < ceil_eff)
					count_q[hit_idx_s1] <= count_q[hit_idx_s1] + DataW'(1);
				stamp_q[hit_idx_s1] <= clock_q;
				if (cmd_s1 == CMD_PUT) value_q[hit_idx_s1] <= value_s1;
			end else if (do_insert) begin
				key_q[ins_idx]   <= key_s1;
				value_q[ins_idx] <= value_s1;
				count_q[ins_idx] <= DataW'(1);
				stamp_q[ins_idx] <= clock_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_hit         <= hit_s1;
			res_read_value  <= (cmd_s1 == CMD_GET && hit_s1) ? value_q[hit_idx_s1] : MissValue;
			res_evicted     <= do_evict;
			res_evicted_key <= do_evict ? key_q[victim_s1] : '0;
			res_occupancy   <= CapW'(resident_s1 +
				((do_insert && !do_evict) ? CntW'(1) : CntW'(0)));
		end
	end
endmodule
`default_nettype wire

// ----- src/lfu_cache_controller.sv -----
// lfu_cache_controller: top level of the LFU cache (LRU tie-break).
// Depends on lfu_pkg, lfu_ctrl, lfu_datapath.
//
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata[63:0]: key, write_value; tuser: command
// m_axis   | out | m_axis_tvalid/tready   | tdata[71:0]: read_value, evicted_key, occupancy, pad;
//          |     |                        | tuser[1:0]: hit, evicted
// cfg      | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One request at a time, in steps: accept/search, commit, result handoff.
// Key match and LFU/LRU victim choice run over all entries against stored state.
// Reset clears valid bits, touch clock and occupancy at once; no clearing pass.
// A waiting result holds the next request until it is taken.
`default_nettype none
module lfu_cache_controller #(
	parameter int unsigned ENTRIES = lfu_pkg::EntriesDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,   // key[31:0], write_value[63:32]
	input  wire logic         s_axis_tuser,   // command
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,   // read_value, evicted_key, occupancy[68:64]
	output logic [1:0]        m_axis_tuser,   // hit, evicted
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import lfu_pkg::*;

	dp_cmd_t cmd;
	logic hit, evicted;
	logic [DataW-1:0] rv, evk;
	logic [CapW-1:0] occ;

	assign cfg_ready = 1'b1;

	lfu_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd
	);

	lfu_datapath #(.ENTRIES(ENTRIES)) u_dp (
		.clk, .arst_n, .cmd,
		.cfg_we   (cfg_valid), .cfg_idx(cfg_index), .cfg_data,
		.req_cmd  (s_axis_tuser),
		.req_key  (s_axis_tdata[31:0]),
		.req_value(s_axis_tdata[63:32]),
		.res_hit(hit), .res_read_value(rv), .res_evicted(evicted),
		.res_evicted_key(evk), .res_occupancy(occ)
	);

	assign m_axis_tdata = {3'b000, occ, evk, rv};
	assign m_axis_tuser = {evicted, hit};
endmodule
`default_nettype wire

// ----- src/lfu_checker.sv -----
// lfu_checker: port-level assertions for lfu_cache_controller, bound to the top.
// Depends on nothing else.
`default_nettype none
module lfu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [71:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);
	// a miss never reports a value
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'hFFFF_FFFF)
		else $error("miss with value");
	// eviction never on a hit
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("eviction on hit");
	// no key reported when nothing was evicted
	a_evk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd0)
		else $error("stray evicted key");
	// busy after an accepted transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accept while busy");
endmodule

bind lfu_cache_controller lfu_checker u_lfu_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire
